[hdl/sil_pkg.sv]
package sil_pkg;

  localparam int WORD_W = 36;
  localparam int HALF_W = 18;

  localparam logic [WORD_W-1:0] LOADER_END = 36'o254000000001;
  localparam logic [WORD_W-1:0] PTR_STEP   = 36'o000001000001;
  localparam logic [HALF_W-1:0] OP_JUMPA   = 18'o324000;
  localparam logic [HALF_W-1:0] OP_JRST    = 18'o254000;

  // result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DEPOSIT,
    KIND_START,
    KIND_ERROR
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [HALF_W-1:0]  address;
    logic [WORD_W-1:0]  data;
  } result_t;

  typedef struct packed {
    logic push;
    logic finished;
  } front_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hdl/sil_front.sv]
module sil_front
  import sil_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [WORD_W-1:0]   image_word,
  input  logic                end_of_input,
  output result_t             res,
  output front_status_t       status
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_HEADER,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t            phase, phase_next;
  logic              finished, finished_next;
  logic              store_en, store_en_next;
  logic [WORD_W-1:0] ptr, ptr_next;
  logic [WORD_W-1:0] csum, csum_next;
  logic [WORD_W-1:0] ptr_inc;
  logic              push;

  assign ptr_inc = ptr + PTR_STEP;

  always_comb begin
    phase_next    = phase;
    finished_next = finished;
    store_en_next = store_en;
    ptr_next      = ptr;
    csum_next     = csum;
    push          = 1'b0;
    res           = '{kind: KIND_DEPOSIT, address: '0, data: '0};
    if (take && !finished) begin
      if (end_of_input) begin
        push          = 1'b1;
        res.kind      = KIND_ERROR;
        finished_next = 1'b1;
      end else begin
        unique case (phase)
          PH_SKIP: begin
            if (image_word == LOADER_END) phase_next = PH_HEADER;
          end
          PH_HEADER: begin
            if (!image_word[WORD_W-1]) begin
              // end header: must be a jump
              push          = 1'b1;
              finished_next = 1'b1;
              if (image_word[WORD_W-1:HALF_W] == OP_JUMPA ||
                  image_word[WORD_W-1:HALF_W] == OP_JRST) begin
                res.kind    = KIND_START;
                res.address = image_word[HALF_W-1:0];
              end else begin
                res.kind    = KIND_ERROR;
              end
            end else begin
              ptr_next      = image_word;
              csum_next     = image_word;
              store_en_next = image_word[HALF_W-1:0] != '0;
              phase_next    = PH_DATA;
            end
          end
          PH_DATA: begin
            csum_next = {csum[WORD_W-2:0], csum[WORD_W-1]} + image_word;
            if (store_en) begin
              push        = 1'b1;
              res.kind    = KIND_DEPOSIT;
              res.address = ptr[HALF_W-1:0];
              res.data    = image_word;
            end
            ptr_next = ptr_inc;
            if (ptr_inc[WORD_W-1:HALF_W] == '0) phase_next = PH_CHECK;
          end
          PH_CHECK: begin
            if (image_word != csum) begin
              push          = 1'b1;
              res.kind      = KIND_ERROR;
              finished_next = 1'b1;
            end else begin
              phase_next = PH_HEADER;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SKIP;
      finished <= 1'b0;
      store_en <= 1'b0;
    end else begin
      phase    <= phase_next;
      finished <= finished_next;
      store_en <= store_en_next;
    end
    ptr  <= ptr_next;
    csum <= csum_next;
  end

  assign status = '{push: push, finished: finished};

endmodule

[hdl/sil_queue.sv]
module sil_queue
  import sil_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  result_t        wr_res,
  input  logic           pop,
  output result_t        rd_res,
  output queue_status_t  status
);

  result_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_res       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (do_push) slots[wr_ptr] <= wr_res;
  end

endmodule

[hdl/sil_back.sv]
module sil_back
  import sil_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  result_t  q_res,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  out_res
);

  // output register: refill when empty or when the held word leaves
  assign q_pop = !q_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !q_empty;
    end
    if (q_pop) out_res <= q_res;
  end

endmodule

[hdl/sblk_image_loader_top.sv]
// SBLK image loader.
// Input channel: one 36-bit image word (or an end-of-input mark) per word,
// accepted when in_valid is high and in_stall low. Output channel: one
// result word (kind, address, data) when out_valid is high and out_stall
// low. Kinds: deposit, start address found, format error.
// Loader words are skipped up to JRST 1; blocks are then parsed, each data
// word of a non-symbol block giving a deposit. An end header gives the start
// PC; a bad jump, checksum mismatch or end of input gives a format error.
// After a start or an error, input is still accepted but ignored.
// Throughput: one word per cycle while the queue has room. The front parser
// settles each word in the cycle it is accepted; the result enters a 4-entry
// queue at that edge and moves on to the output register in queue order once
// the register is empty or its held word leaves, which raises out_valid.
// When the receiver stalls, the output register holds its word and the
// queue fills; in_stall rises only once the queue is full.
// Reset (rst, synchronous) returns the parser to skipping loader words and
// empties the queue and the output register.
module sblk_image_loader_top
  import sil_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] image_word,
  input  logic              end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [HALF_W-1:0] address,
  output logic [WORD_W-1:0] data
);

  front_status_t f_status;
  queue_status_t q_status;
  result_t       f_res, q_res, o_res;
  logic          take, q_pop;

  // front accepts whenever the queue has room
  assign in_stall = q_status.full;
  assign take     = in_valid && !in_stall;

  sil_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .image_word   (image_word),
    .end_of_input (end_of_input),
    .res          (f_res),
    .status       (f_status)
  );

  sil_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (f_status.push),
    .wr_res (f_res),
    .pop    (q_pop),
    .rd_res (q_res),
    .status (q_status)
  );

  sil_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_status.empty),
    .q_res     (q_res),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (o_res)
  );

  assign kind    = o_res.kind;
  assign address = o_res.address;
  assign data    = o_res.data;

`ifndef SYNTHESIS
  // nothing is produced once the stream has finished
  a_quiet_after_finish: assert property (@(posedge clk) disable iff (rst)
    f_status.finished |-> !f_status.push)
    else $error("result pushed after stream finished");

  // a push never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_status.push |-> !q_status.full)
    else $error("push into full queue");

  // only deposits carry data
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && o_res.kind != KIND_DEPOSIT |-> data == '0)
    else $error("non-deposit result with data");

  // the output register is only loaded from a non-empty queue
  a_load_source: assert property (@(posedge clk) disable iff (rst)
    !$past(out_valid) && out_valid |-> !$past(q_status.empty))
    else $error("output loaded from empty queue");
`endif

endmodule

[test/sblk_result_checker.sv]
`timescale 1ns / 1ps

module sblk_result_checker
  import sil_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [WORD_W-1:0] image_word,
  input  logic              end_of_input,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        kind,
  input  logic [HALF_W-1:0] address,
  input  logic [WORD_W-1:0] data,
  output int                mismatches,
  output int                outstanding
);

  typedef enum logic [1:0] {
    SEEK_LOADER_END,
    AWAIT_HEADER,
    TAKE_DATA,
    TAKE_CHECKSUM
  } parse_phase_t;

  parse_phase_t      phase;
  logic [WORD_W-1:0] blk_ptr;
  logic [WORD_W-1:0] csum;
  logic              store_en;
  logic              stopped;
  result_t           awaited_results[$];
  result_t           oldest;
  int                bad_count = 0;

  // Works out what one accepted word should produce; queues it if anything.
  task automatic parse_word(input logic [WORD_W-1:0] w, input logic eoi);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    if (stopped) begin
      // start or error already seen: word dropped
    end else if (eoi) begin
      stopped = 1'b1;
      awaited_results.push_back(r);
    end else begin
      case (phase)
        SEEK_LOADER_END: begin
          if (w == LOADER_END) phase = AWAIT_HEADER;
        end
        AWAIT_HEADER: begin
          if (!w[WORD_W-1]) begin
            stopped = 1'b1;
            if (w[WORD_W-1:HALF_W] == OP_JUMPA || w[WORD_W-1:HALF_W] == OP_JRST) begin
              r.kind    = KIND_START;
              r.address = w[HALF_W-1:0];
            end
            awaited_results.push_back(r);
          end else begin
            blk_ptr  = w;
            csum     = w;
            store_en = (w[HALF_W-1:0] != '0);
            phase    = TAKE_DATA;
          end
        end
        TAKE_DATA: begin
          csum = {csum[WORD_W-2:0], csum[WORD_W-1]} + w;
          if (store_en) begin
            r.kind    = KIND_DEPOSIT;
            r.address = blk_ptr[HALF_W-1:0];
            r.data    = w;
            awaited_results.push_back(r);
          end
          // full-width add: right-half carry runs into the count
          blk_ptr = blk_ptr + PTR_STEP;
          if (blk_ptr[WORD_W-1:HALF_W] == '0) phase = TAKE_CHECKSUM;
        end
        default: begin
          if (w != csum) begin
            stopped = 1'b1;
            awaited_results.push_back(r);
          end else begin
            phase = AWAIT_HEADER;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase    = SEEK_LOADER_END;
      blk_ptr  = '0;
      csum     = '0;
      store_en = 1'b0;
      stopped  = 1'b0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall) parse_word(image_word, end_of_input);
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected word: kind %0d address %0o data %0o",
                     $realtime, kind, address, data);
        end else begin
          oldest = awaited_results.pop_front();
          if (kind !== oldest.kind || address !== oldest.address || data !== oldest.data) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: mismatch: expected kind %0d address %0o data %0o, got kind %0d address %0o data %0o",
                       $realtime, oldest.kind, oldest.address, oldest.data,
                       kind, address, data);
          end
        end
      end
    end
    mismatches  <= bad_count;
    outstanding <= awaited_results.size();
  end

endmodule

[test/sblk_image_loader_top_tb.sv]
`timescale 1ns / 1ps

module sblk_image_loader_top_tb;
  import sil_pkg::*;

  // Words in the main image before the stream is closed, and the point at
  // which both sides stop idling so the tail of the run is at full rate.
  localparam int MAIN_WORDS  = 1900;
  localparam int CALM_FROM   = 1650;
  // Longest stretch with no word moving on either channel before giving up.
  localparam int QUIET_LIMIT = 400;
  // Extra wait after the last awaited result, before the verdict.
  localparam int DRAIN_CYCLES = 8;

  typedef enum {
    END_JRST,
    END_JUMPA,
    END_BAD_JUMP,
    END_BAD_SUM,
    END_EOI
  } stream_end_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [WORD_W-1:0] image_word;
  logic              end_of_input;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        kind;
  logic [HALF_W-1:0] address;
  logic [WORD_W-1:0] data;

  int mismatches;
  int outstanding;
  int words_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  logic calm = 1'b0;

  sblk_image_loader_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .image_word   (image_word),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .address      (address),
    .data         (data)
  );

  sblk_result_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .image_word   (image_word),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .address      (address),
    .data         (data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver side: stall bursts dropped in at random,
  // with long clear stretches between them; none once the run goes calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand36();
    logic [WORD_W-1:0] v;
    v[31:0]        = $urandom;
    v[WORD_W-1:32] = 4'($urandom_range(0, 15));
    return v;
  endfunction

  // Data words lean on the awkward values: all ones (plain data, not an
  // end mark), zero, and the loader-end pattern appearing mid-block.
  function automatic logic [WORD_W-1:0] pick_data();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = '1;
      1:       v = '0;
      2:       v = LOADER_END;
      default: v = rand36();
    endcase
    return v;
  endfunction

  // AOBJN header: negative count on the left, address on the right. Mostly
  // short blocks, a zero address now and then (symbol table) and some near
  // the top of memory so the right half wraps into the count.
  function automatic logic [WORD_W-1:0] pick_header();
    logic [HALF_W-1:0] count;
    logic [HALF_W-1:0] rh;
    logic [HALF_W:0]   reach;
    logic [WORD_W-1:0] r;
    count = ($urandom_range(0, 9) == 0) ? 18'($urandom_range(9, 40))
                                        : 18'($urandom_range(1, 8));
    r = rand36();
    case ($urandom_range(0, 7))
      0:       rh = '0;
      1:       rh = 18'o777777 - 18'($urandom_range(0, 10));
      default: rh = r[HALF_W-1:0];
    endcase
    // A wrap on the very last word would leave the count at one and run the
    // block on for a quarter of a million words; nudge the address instead.
    reach = rh + count;
    if (reach == 19'o1000000) rh = rh - 1'b1;
    return {18'd0 - count, rh};
  endfunction

  // One word on the input channel, with an occasional sender gap first.
  task automatic put_word(input logic [WORD_W-1:0] w, input logic eoi);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    image_word   <= w;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Header, data words up to the point where the count runs out, then the
  // rotate-and-add checksum (one bit flipped when a bad sum is wanted).
  task automatic send_block(input logic [WORD_W-1:0] hdr, input logic bad_sum);
    logic [WORD_W-1:0] ptr;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] w;
    ptr = hdr;
    sum = hdr;
    put_word(hdr, 1'b0);
    do begin
      w   = pick_data();
      sum = {sum[WORD_W-2:0], sum[WORD_W-1]} + w;
      put_word(w, 1'b0);
      ptr = ptr + PTR_STEP;
    end while (ptr[WORD_W-1:HALF_W] != '0);
    if (bad_sum) sum[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
    put_word(sum, 1'b0);
  endtask

  initial begin
    stream_end_t       ending;
    logic [HALF_W-1:0] op;
    logic [WORD_W-1:0] w;

    rst          = 1'b1;
    in_valid     = 1'b0;
    image_word   = '0;
    end_of_input = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Loader words, including near misses of JRST 1, all skipped.
    put_word('0, 1'b0);
    put_word('1, 1'b0);
    put_word(36'o254000000000, 1'b0);
    put_word(36'o254000000003, 1'b0);
    put_word(36'o654000000001, 1'b0);
    repeat ($urandom_range(0, 20)) put_word(rand36(), 1'b0);
    put_word(LOADER_END, 1'b0);

    // Symbol table block: zero address, so no deposits.
    send_block({18'd0 - 18'd2, 18'd0}, 1'b0);
    // Count of one at the second-highest address.
    send_block({18'o777777, 18'o777776}, 1'b0);
    // Address at the top: the right half wraps and shortens the block.
    send_block({18'd0 - 18'd2, 18'o777777}, 1'b0);
    // Lowest non-zero address.
    send_block({18'd0 - 18'd3, 18'd1}, 1'b0);

    // Bulk of the image: well-formed blocks with random content.
    while (words_sent < MAIN_WORDS) begin
      if (words_sent >= CALM_FROM) calm <= 1'b1;
      send_block(pick_header(), 1'b0);
    end

    // Close the stream one way; the seed picks which.
    ending = stream_end_t'($urandom_range(0, 4));
    w = rand36();
    case (ending)
      END_JRST:  put_word({OP_JRST, w[HALF_W-1:0]}, 1'b0);
      END_JUMPA: put_word({OP_JUMPA, w[HALF_W-1:0]}, 1'b0);
      END_BAD_JUMP: begin
        case ($urandom_range(0, 2))
          0:       op = '0;
          1:       op = OP_JRST ^ 18'o000001;
          default: op = {1'b0, w[WORD_W-2:HALF_W]};
        endcase
        if (op == OP_JRST || op == OP_JUMPA) op = 18'o000001;
        put_word({op, w[HALF_W-1:0]}, 1'b0);
      end
      END_BAD_SUM: send_block(pick_header(), 1'b1);
      default: begin
        // end of input either at a header or part-way through a block
        if ($urandom_range(0, 1) == 1) begin
          put_word({18'd0 - 18'd4, 18'd1}, 1'b0);
          put_word(pick_data(), 1'b0);
        end
        put_word(w, 1'b1);
      end
    endcase

    // Everything from here on must be dropped by the block.
    put_word(LOADER_END, 1'b1);
    put_word('1, 1'b1);
    repeat (20) put_word(rand36(), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
